// ----- rtl/core/hbw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbw_pkg
// shared types and constants of the heartbeat watchdog supervisor
// ----------------------------------------------------------------------------
package hbw_pkg;

    // configuration registers are all 16 bits wide
    localparam int CFG_W = 16;

    localparam logic [CFG_W-1:0] GRACE_RESET   = 16'd8000;
    localparam logic [CFG_W-1:0] STALL_RESET   = 16'd2500;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd4000;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_GRACE   = 2'd0,
        REG_STALL   = 2'd1,
        REG_TIMEOUT = 2'd2
    } cfg_idx_t;

    // stalled task codes
    localparam logic [1:0] TASK_NONE = 2'd0;

    // one result item
    typedef struct packed {
        logic       refresh;
        logic       in_grace;
        logic       stall_report;
        logic [1:0] stalled_task;
        logic       reset_request;
    } result_t;

endpackage

// ----- rtl/core/hbw_tick.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbw_tick
// next-state and result logic for one millisecond tick
// ----------------------------------------------------------------------------
module hbw_tick
    import hbw_pkg::*;
#(
    parameter int TIME_WIDTH = 16
)
(
    input  logic                  kick_first,
    input  logic                  kick_second,
    input  logic                  poll,
    input  logic [CFG_W-1:0]      grace_ms,
    input  logic [CFG_W-1:0]      stall_ms,
    input  logic [CFG_W-1:0]      timeout_ms,
    input  logic [TIME_WIDTH-1:0] elapsed,
    input  logic [TIME_WIDTH-1:0] first_age,
    input  logic [TIME_WIDTH-1:0] second_age,
    input  logic                  stall_logged,
    input  logic [CFG_W-1:0]      countdown,
    input  logic                  expired,
    output logic [TIME_WIDTH-1:0] elapsed_next,
    output logic [TIME_WIDTH-1:0] first_age_next,
    output logic [TIME_WIDTH-1:0] second_age_next,
    output logic                  stall_logged_next,
    output logic [CFG_W-1:0]      countdown_next,
    output logic                  expired_next,
    output result_t               res
);

    localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
    localparam logic [TIME_WIDTH-1:0] TIME_ONE = TIME_WIDTH'(1);
    localparam logic [CFG_W-1:0]      CNT_ONE  = CFG_W'(1);

    logic       grace;
    logic       stall_first;
    logic       stall_second;
    logic [1:0] task_bits;
    logic       refresh;
    logic       report;

    // saturating advance, then kicks clear their own age
    always_comb
    begin
        elapsed_next    = (elapsed == TIME_MAX) ? elapsed : elapsed + TIME_ONE;
        first_age_next  = (first_age == TIME_MAX) ? first_age : first_age + TIME_ONE;
        second_age_next = (second_age == TIME_MAX) ? second_age : second_age + TIME_ONE;
        if (kick_first)
        begin
            first_age_next = '0;
        end
        if (kick_second)
        begin
            second_age_next = '0;
        end
    end

    assign grace        = CMP_W'(elapsed_next) < CMP_W'(grace_ms);
    assign stall_first  = CMP_W'(first_age_next) >= CMP_W'(stall_ms);
    assign stall_second = CMP_W'(second_age_next) >= CMP_W'(stall_ms);

    always_comb
    begin
        refresh           = 1'b0;
        report            = 1'b0;
        task_bits         = TASK_NONE;
        stall_logged_next = stall_logged;
        if (poll)
        begin
            if (grace)
            begin
                refresh = 1'b1;
            end
            else
            begin
                task_bits = {stall_second, stall_first};
                if (task_bits == TASK_NONE)
                begin
                    refresh = 1'b1;
                end
                else if (!stall_logged)
                begin
                    stall_logged_next = 1'b1;
                    report            = 1'b1;
                end
            end
        end
    end

    // watchdog downcounter, stops at zero
    always_comb
    begin
        if (refresh)
        begin
            countdown_next = timeout_ms;
        end
        else if (countdown != '0)
        begin
            countdown_next = countdown - CNT_ONE;
        end
        else
        begin
            countdown_next = countdown;
        end
        expired_next = expired | (countdown_next == '0);
    end

    always_comb
    begin
        res.refresh       = refresh;
        res.in_grace      = grace;
        res.stall_report  = report;
        res.stalled_task  = task_bits;
        res.reset_request = expired_next;
    end

endmodule

// ----- rtl/core/hbw_out_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbw_out_queue
// two-entry result buffer, keeps input accepting while output is stalled until both entries fill
// ----------------------------------------------------------------------------
module hbw_out_queue
    import hbw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t head
);

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign head      = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        if (push)
        begin
            if (count_next == 2'd0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
            count_next = count_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full result buffer");

    a_pop_only_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("result buffer lost a push");

endmodule

// ----- rtl/core/heartbeat_watchdog_supervisor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_watchdog_supervisor
// per-millisecond heartbeat ages, supervise polls and watchdog countdown
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  -------------------------------------------
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data (grace, stall, timeout)
//  in       in_valid/in_ready     kick_first, kick_second, poll (one tick)
//  out      out_valid/out_ready   refresh, in_grace, stall_report,
//                                 stalled_task, reset_request
//
//  one tick per clock while in_ready is high: the state registers update in
//  the cycle of the transfer and the result enters a two-entry output buffer
//  in_ready drops only when both buffer entries wait on a stalled output
//  reset clears ages and elapsed time, reloads register defaults and the
//  countdown; cfg_ready is always high
//
module heartbeat_watchdog_supervisor
    import hbw_pkg::*;
#(
    parameter int TIME_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    // tick input
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kick_first,
    input  logic             kick_second,
    input  logic             poll,
    // result output
    output logic             out_valid,
    input  logic             out_ready,
    output logic             refresh,
    output logic             in_grace,
    output logic             stall_report,
    output logic [1:0]       stalled_task,
    output logic             reset_request
);

    // configuration registers
    logic [CFG_W-1:0]      grace_reg;
    logic [CFG_W-1:0]      stall_reg;
    logic [CFG_W-1:0]      timeout_reg;

    // supervisor state
    logic [TIME_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [TIME_WIDTH-1:0] first_age_reg, first_age_next;
    logic [TIME_WIDTH-1:0] second_age_reg, second_age_next;
    logic                  stall_logged_reg, stall_logged_next;
    logic [CFG_W-1:0]      countdown_reg, countdown_next;
    logic                  expired_reg, expired_next;

    result_t               tick_res;
    result_t               head;
    logic                  queue_full;
    logic                  in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign in_fire   = in_valid && in_ready;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg   <= GRACE_RESET;
            stall_reg   <= STALL_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_GRACE:   grace_reg   <= cfg_data;
                REG_STALL:   stall_reg   <= cfg_data;
                REG_TIMEOUT: timeout_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // tick evaluation
    hbw_tick #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_tick (
        .kick_first        (kick_first),
        .kick_second       (kick_second),
        .poll              (poll),
        .grace_ms          (grace_reg),
        .stall_ms          (stall_reg),
        .timeout_ms        (timeout_reg),
        .elapsed           (elapsed_reg),
        .first_age         (first_age_reg),
        .second_age        (second_age_reg),
        .stall_logged      (stall_logged_reg),
        .countdown         (countdown_reg),
        .expired           (expired_reg),
        .elapsed_next      (elapsed_next),
        .first_age_next    (first_age_next),
        .second_age_next   (second_age_next),
        .stall_logged_next (stall_logged_next),
        .countdown_next    (countdown_next),
        .expired_next      (expired_next),
        .res               (tick_res)
    );

    // state advances only on an input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg      <= '0;
            first_age_reg    <= '0;
            second_age_reg   <= '0;
            stall_logged_reg <= 1'b0;
            countdown_reg    <= TIMEOUT_RESET;
            expired_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            elapsed_reg      <= elapsed_next;
            first_age_reg    <= first_age_next;
            second_age_reg   <= second_age_next;
            stall_logged_reg <= stall_logged_next;
            countdown_reg    <= countdown_next;
            expired_reg      <= expired_next;
        end
    end

    // result buffer decouples the output stall from the input
    hbw_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (tick_res),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign refresh       = head.refresh;
    assign in_grace      = head.in_grace;
    assign stall_report  = head.stall_report;
    assign stalled_task  = head.stalled_task;
    assign reset_request = head.reset_request;

    // expired never clears once latched
    a_expired_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        expired_reg |=> expired_reg)
        else $error("watchdog expiry flag cleared");

    // a stall is reported only once per reset
    a_report_once: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && tick_res.stall_report) |-> !stall_logged_reg)
        else $error("stall reported twice");

    // a refresh reloads the countdown with the timeout value
    a_refresh_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && tick_res.refresh) |=> (countdown_reg == $past(timeout_reg)))
        else $error("refresh did not reload countdown");

    // refresh and a stalled task code never come together
    a_refresh_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && tick_res.refresh) |-> (tick_res.stalled_task == TASK_NONE))
        else $error("refresh with stalled task");

endmodule
